@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL.
// All checks run on the rising edge of clk and are off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define MPPT_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define MPPT_ASSERT_NEXT(label, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/mppt_pkg.sv @@
// ----------------------------------------------------------------------------
// mppt_pkg
// Types and constants shared by the MPPT tracker and its stream interface.
// ----------------------------------------------------------------------------
package mppt_pkg;

	localparam int unsigned VOLT_W = 14;
	localparam int unsigned CURR_W = 16;
	localparam int unsigned POWER_W = 16;
	localparam int unsigned OFFSET_W = 12;
	localparam int unsigned STEP_W = 8;
	localparam int unsigned THRESH_W = 11;
	localparam int unsigned LOWCNT_W = 4;

	// Tracker constants
	localparam logic [VOLT_W-1:0] RESTART_REF = 14'd8800;
	localparam logic [VOLT_W-1:0] MAX_SETPOINT_RST = 14'd13600;
	localparam logic [VOLT_W-1:0] MIN_SETPOINT_RST = 14'd0;
	localparam logic signed [OFFSET_W-1:0] OFFSET_RST = 12'sd0;
	localparam logic [STEP_W-1:0] STEP_RST = 8'd24;
	localparam logic [THRESH_W-1:0] THRESH_RST = 11'd32;
	localparam logic signed [VOLT_W:0] NEAR_BAND = 15'sd80;
	localparam logic signed [VOLT_W+2:0] SLOW_RAMP = 17'sd80;
	localparam logic signed [VOLT_W+2:0] FAST_RAMP = 17'sd320;

	// Operation codes
	typedef enum logic [1:0] {
		OP_SAMPLE  = 2'd0,
		OP_FORCE   = 2'd1,
		OP_RESTART = 2'd2
	} opcode_t;

	// Register indexes (word address)
	localparam int unsigned REG_IDX_W = 3;
	localparam logic [REG_IDX_W-1:0] REG_MIN_SETPOINT = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_MAX_SETPOINT = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_CURRENT_OFFSET = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_STEP_SIZE = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_CURRENT_THRESHOLD = 3'd4;

	typedef struct packed {
		logic [1:0] opcode;
		logic [VOLT_W-1:0] pv_voltage;
		logic signed [CURR_W-1:0] pv_current;
		logic signed [POWER_W-1:0] pv_power;
		logic [VOLT_W-1:0] forced_setpoint;
	} in_item_t;

	typedef struct packed {
		logic [VOLT_W-1:0] setpoint;
		logic window_done;
	} out_item_t;

endpackage

@@ rtl/mppt_stream_if.sv @@
// ----------------------------------------------------------------------------
// mppt_stream_if
// Valid/ready channel carrying one item of payload type T.
// ----------------------------------------------------------------------------
interface mppt_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/mppt_perturb_observe.sv @@
// ----------------------------------------------------------------------------
// mppt_perturb_observe
// Perturb-and-observe MPPT tracker with windowed voltage/power averages.
// Pipeline: input reg then result reg; an accepted item moves into the result reg once that slot frees up.
// Throughput: 1 item per cycle while results.ready holds; all tracker state updates in the
// compute logic between the input register and the result register.
// Reset: arst_n clears pipeline valids and tracker state, and loads register
// reset values; setpoint restarts at 8800. No clearing pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mppt_perturb_observe import mppt_pkg::*; #(
	parameter int unsigned AVERAGE_SHIFT = 3,
	parameter int unsigned FAST_RAMP_AFTER = 10
) (
	input  logic clk,
	input  logic arst_n,
	// configuration port
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [4:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	// item channels
	mppt_stream_if.sink samples,
	mppt_stream_if.source results
);

	// Accumulator widths grow with the window length
	localparam int unsigned VSUM_W = VOLT_W + AVERAGE_SHIFT;
	localparam int unsigned PSUM_W = POWER_W + AVERAGE_SHIFT;
	localparam logic [LOWCNT_W:0] FAST_AFTER = (LOWCNT_W + 1)'(FAST_RAMP_AFTER);

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [VOLT_W-1:0] min_setpoint_q;
	logic [VOLT_W-1:0] max_setpoint_q;
	logic signed [OFFSET_W-1:0] current_offset_q;
	logic [STEP_W-1:0] step_size_q;
	logic [THRESH_W-1:0] current_threshold_q;
	logic cfg_we;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_setpoint_q <= MIN_SETPOINT_RST;
			max_setpoint_q <= MAX_SETPOINT_RST;
			current_offset_q <= OFFSET_RST;
			step_size_q <= STEP_RST;
			current_threshold_q <= THRESH_RST;
		end else if (cfg_we) begin
			unique case (paddr[4:2])
				REG_MIN_SETPOINT: min_setpoint_q <= pwdata[VOLT_W-1:0];
				REG_MAX_SETPOINT: max_setpoint_q <= pwdata[VOLT_W-1:0];
				REG_CURRENT_OFFSET: current_offset_q <= $signed(pwdata[OFFSET_W-1:0]);
				REG_STEP_SIZE: step_size_q <= pwdata[STEP_W-1:0];
				REG_CURRENT_THRESHOLD: current_threshold_q <= pwdata[THRESH_W-1:0];
				default: ;	// drop writes outside the register map
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[4:2])
			REG_MIN_SETPOINT: prdata = {18'd0, min_setpoint_q};
			REG_MAX_SETPOINT: prdata = {18'd0, max_setpoint_q};
			REG_CURRENT_OFFSET: prdata = {{20{current_offset_q[OFFSET_W-1]}}, current_offset_q};
			REG_STEP_SIZE: prdata = {24'd0, step_size_q};
			REG_CURRENT_THRESHOLD: prdata = {21'd0, current_threshold_q};
			default: prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Input register: hold one item; advance whenever the result slot frees up
	// ------------------------------------------------------------------
	logic valid_s1;
	in_item_t item_s1;
	logic out_valid_q;
	out_item_t out_item_q;
	logic advance;
	logic fire_s1;

	assign advance = !out_valid_q || results.ready;
	assign fire_s1 = valid_s1 && advance;
	assign samples.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (samples.ready) begin
			valid_s1 <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (samples.valid && samples.ready) begin
			item_s1 <= samples.data;
		end
	end

	// ------------------------------------------------------------------
	// Tracker state
	// ------------------------------------------------------------------
	logic [AVERAGE_SHIFT-1:0] count_q;
	logic [VSUM_W-1:0] vsum_q;
	logic signed [PSUM_W-1:0] psum_q;
	logic [VOLT_W-1:0] prev_v_q;
	logic signed [POWER_W-1:0] prev_p_q;
	logic [VOLT_W-1:0] ref_q;
	logic [LOWCNT_W-1:0] lowcnt_q;

	logic [AVERAGE_SHIFT-1:0] count_n;
	logic [VSUM_W-1:0] vsum_n;
	logic signed [PSUM_W-1:0] psum_n;
	logic [VOLT_W-1:0] prev_v_n;
	logic signed [POWER_W-1:0] prev_p_n;
	logic [VOLT_W-1:0] ref_n;
	logic [LOWCNT_W-1:0] lowcnt_n;
	logic done_c;

	// Window arithmetic
	logic [VSUM_W-1:0] vsum_add;
	logic signed [PSUM_W-1:0] psum_add;
	logic window_end;
	logic [VOLT_W-1:0] avg_v;
	logic signed [POWER_W-1:0] avg_p;
	logic signed [CURR_W+1:0] corr_current;
	logic tracking;
	logic signed [VOLT_W:0] gap;
	logic near;
	logic dv_up;
	logic dv_dn;
	logic dp_pos;
	logic step_up;
	logic step_dn;
	logic [LOWCNT_W:0] lowcnt_inc;
	logic signed [VOLT_W+2:0] ref_w;
	logic signed [VOLT_W+2:0] step_w;
	logic signed [VOLT_W+2:0] ref_move;

	always_comb begin
		vsum_add = vsum_q + VSUM_W'(item_s1.pv_voltage);
		psum_add = psum_q + PSUM_W'(item_s1.pv_power);
		window_end = &count_q;
		// floor average: upper bits of the sum (arithmetic for power)
		avg_v = vsum_add[VSUM_W-1:AVERAGE_SHIFT];
		avg_p = psum_add[PSUM_W-1:AVERAGE_SHIFT];

		corr_current = (CURR_W + 2)'(item_s1.pv_current) - (CURR_W + 2)'(current_offset_q);
		tracking = corr_current > $signed({7'd0, current_threshold_q});

		gap = $signed({1'b0, avg_v}) - $signed({1'b0, ref_q});
		near = (gap < NEAR_BAND) && (gap > -NEAR_BAND);
		dv_up = avg_v > prev_v_q;
		dv_dn = avg_v < prev_v_q;
		dp_pos = avg_p > prev_p_q;
		// step toward rising power; flat voltage holds
		step_up = dp_pos ? dv_up : dv_dn;
		step_dn = dp_pos ? dv_dn : dv_up;
		lowcnt_inc = {1'b0, lowcnt_q} + 1'b1;

		ref_w = $signed({3'd0, ref_q});
		step_w = $signed({9'd0, step_size_q});
		ref_move = ref_w;
		if (window_end) begin
			if (tracking) begin
				if (near && step_up) begin
					ref_move = ref_w + step_w;
				end else if (near && step_dn) begin
					ref_move = ref_w - step_w;
				end
			end else if (lowcnt_inc < FAST_AFTER) begin
				ref_move = ref_w - SLOW_RAMP;
			end else begin
				ref_move = ref_w - FAST_RAMP;
			end
		end
	end

	// Next-state select per operation
	always_comb begin
		count_n = count_q;
		vsum_n = vsum_q;
		psum_n = psum_q;
		prev_v_n = prev_v_q;
		prev_p_n = prev_p_q;
		ref_n = ref_q;
		lowcnt_n = lowcnt_q;
		done_c = 1'b0;
		unique case (item_s1.opcode)
			OP_FORCE: begin
				ref_n = item_s1.forced_setpoint;
			end
			OP_RESTART: begin
				count_n = '0;
				vsum_n = '0;
				psum_n = '0;
				prev_v_n = '0;
				prev_p_n = '0;
				ref_n = RESTART_REF;
			end
			OP_SAMPLE: begin
				count_n = count_q + 1'b1;
				vsum_n = vsum_add;
				psum_n = psum_add;
				if (window_end) begin
					done_c = 1'b1;
					vsum_n = '0;
					psum_n = '0;
					if (tracking) begin
						prev_v_n = avg_v;
						prev_p_n = avg_p;
						lowcnt_n = '0;
					end else if (lowcnt_inc < FAST_AFTER) begin
						lowcnt_n = lowcnt_inc[LOWCNT_W-1:0];
					end else begin
						lowcnt_n = FAST_AFTER[LOWCNT_W-1:0];
					end
				end
				// clamp: max first, then min
				if (ref_move > $signed({3'd0, max_setpoint_q})) begin
					ref_n = max_setpoint_q;
				end else if (ref_move < $signed({3'd0, min_setpoint_q})) begin
					ref_n = min_setpoint_q;
				end else begin
					ref_n = ref_move[VOLT_W-1:0];
				end
			end
			default: ;	// unused code: leave state alone
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			vsum_q <= '0;
			psum_q <= '0;
			prev_v_q <= '0;
			prev_p_q <= '0;
			ref_q <= RESTART_REF;
			lowcnt_q <= '0;
		end else if (fire_s1) begin
			count_q <= count_n;
			vsum_q <= vsum_n;
			psum_q <= psum_n;
			prev_v_q <= prev_v_n;
			prev_p_q <= prev_p_n;
			ref_q <= ref_n;
			lowcnt_q <= lowcnt_n;
		end
	end

	// ------------------------------------------------------------------
	// Result register: hold until taken, load as the input stage advances
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			out_item_q.setpoint <= ref_n;
			out_item_q.window_done <= done_c;
		end
	end

	assign results.valid = out_valid_q;
	assign results.data = out_item_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`MPPT_ASSERT(a_lowcnt_sat, {1'b0, lowcnt_q} <= FAST_AFTER, "low-current count past saturation")
	`MPPT_ASSERT_NEXT(a_window_clears, fire_s1 && done_c, (count_q == '0) && (vsum_q == '0) && (psum_q == '0), "window close left accumulators dirty")
	`MPPT_ASSERT_NEXT(a_clamped, fire_s1 && (item_s1.opcode == OP_SAMPLE) && !cfg_we, (ref_q <= max_setpoint_q) || (ref_q == min_setpoint_q), "setpoint escaped clamp after a sample")
	`MPPT_ASSERT_NEXT(a_result_loaded, fire_s1, out_valid_q && (out_item_q.setpoint == ref_q), "result does not match tracker setpoint")

endmodule
